// ===== rtl/iee_pkg.sv =====
// Shared types and constants for the integer expression evaluator.
`default_nettype none
package iee_pkg;
  // arithmetic width of the evaluator
  localparam int VALUE_BITS = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_DIV0   = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  // pending multiplicative operator
  localparam logic [1:0] MOP_NONE = 2'd0;
  localparam logic [1:0] MOP_MUL  = 2'd1;
  localparam logic [1:0] MOP_DIV  = 2'd2;

  // minus run: odd or even count after a number, or a negated literal
  localparam logic [1:0] MR_NONE = 2'd0;
  localparam logic [1:0] MR_ODD  = 2'd1;
  localparam logic [1:0] MR_EVEN = 2'd2;
  localparam logic [1:0] MR_NEG  = 2'd3;

  typedef enum logic [2:0] {
    CK_DIGIT = 3'd0,
    CK_SPACE = 3'd1,
    CK_PLUS  = 3'd2,
    CK_MINUS = 3'd3,
    CK_MUL   = 3'd4,
    CK_DIV   = 3'd5,
    CK_BAD   = 3'd6
  } char_kind_t;

  // classified request handed from front to back
  typedef struct packed {
    char_kind_t kind;
    logic [3:0] digit;
    logic       last;
  } tok_t;
endpackage
`default_nettype wire

// ===== rtl/iee_front.sv =====
// Front end: accepts characters, classifies them and queues them for the back end.
`default_nettype none
module iee_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       in_char_code,
  input  wire              in_last_char,
  output logic             q_valid,
  output iee_pkg::tok_t    q_tok,
  input  wire              q_take
);
  import iee_pkg::*;
  localparam int DEPTH = 4;
  tok_t         mem [DEPTH];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;
  tok_t         t;
  logic         push, pop;

  always_comb begin
    t.last  = in_last_char;
    t.digit = 4'(in_char_code - CH_ZERO);
    if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) t.kind = CK_DIGIT;
    else if (in_char_code == CH_SPACE ||
             (in_char_code >= CH_TAB && in_char_code <= CH_CR)) t.kind = CK_SPACE;
    else if (in_char_code == CH_PLUS)  t.kind = CK_PLUS;
    else if (in_char_code == CH_MINUS) t.kind = CK_MINUS;
    else if (in_char_code == CH_STAR)  t.kind = CK_MUL;
    else if (in_char_code == CH_SLASH) t.kind = CK_DIV;
    else t.kind = CK_BAD;
  end

  assign in_stall = (cnt_r == 3'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 3'd0);
  assign pop      = q_valid && q_take;
  assign q_tok    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/iee_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating.
`default_nettype none
module iee_div #(
  parameter int W = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire  signed [W-1:0] a,
  input  wire  signed [W-1:0] b,
  output logic               done,
  output logic signed [W-1:0] q
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0]  rem_r, quo_r, dvs_r;
  logic          neg_r, busy_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    trial;
  logic [W-1:0]  rem_sh;

  assign rem_sh = {rem_r[W-2:0], quo_r[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign done   = busy_r && (cnt_r == CW'(0));
  assign q      = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(W);
      rem_r  <= '0;
      quo_r  <= a[W-1] ? -a : a;
      dvs_r  <= b[W-1] ? -b : b;
      neg_r  <= a[W-1] ^ b[W-1];
    end else if (busy_r) begin
      if (cnt_r == CW'(0)) busy_r <= 1'b0;
      else begin
        cnt_r <= cnt_r - CW'(1);
        if (!trial[W]) begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/iee_back.sv =====
// Back end: parse state machine and checked arithmetic on queued characters.
`default_nettype none
module iee_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  iee_pkg::tok_t       q_tok,
  output logic                q_take,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [31:0]  out_value,
  output logic [1:0]          out_status
);
  import iee_pkg::*;

  localparam int W = VALUE_BITS;

  typedef enum logic [5:0] {
    PH_START = 6'b000001, PH_UNARY = 6'b000010, PH_NUMBER = 6'b000100,
    PH_AFTER = 6'b001000, PH_OPND  = 6'b010000, PH_MRUN   = 6'b100000
  } phase_t;
  // sequencing of one character
  typedef enum logic [5:0] {
    SQ_IDLE = 6'b000001, SQ_LIT  = 6'b000010, SQ_MULC = 6'b000100,
    SQ_DIVW = 6'b001000, SQ_TERM = 6'b010000, SQ_EMIT = 6'b100000
  } seq_t;

  localparam logic [W:0] LIM    = (W+1)'(1) << (W-1);
  localparam logic [W:0] LIM_M1 = LIM - (W+1)'(1);
  localparam logic signed [W-1:0]   VMIN = W'(LIM);
  localparam logic signed [2*W-1:0] PMAX = (2*W)'(LIM_M1);
  localparam logic signed [2*W-1:0] PMIN = -((2*W)'(LIM));

  phase_t phase_r, phase_nxt, cur_ph;
  seq_t   seq_r, after_lit, after_term;
  logic signed [W-1:0]   sum_r, term_r, lit_v, div_q;
  logic signed [2*W-1:0] prod_r;
  logic signed [W:0]     sres;
  logic [W:0]   num_r, num_nxt, fnum_r;
  logic [W+4:0] num_x10;
  logic [1:0]   mop_r, mop_nxt, mrun_r, mrun_nxt, err_r, err_nxt, fmop_r;
  logic         asgn_r, asgn_nxt, fasgn_r, fneg_r, fterm_r, femit_r;
  logic         syn, lit_mid, term_mid, fin_fold, lit_ovf;
  logic         div_start, div_done, emit_fire;

  iee_div #(.W(W)) u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
    .a(term_r), .b(lit_v), .done(div_done), .q(div_q));

  assign q_take    = (seq_r == SQ_IDLE);
  assign emit_fire = (seq_r == SQ_EMIT) && !(out_valid && out_stall);
  assign num_x10   = {4'd0, num_r} * (W+5)'(10) + (W+5)'(q_tok.digit);

  // parse step for the token at the head of the queue
  always_comb begin
    phase_nxt = phase_r; num_nxt = num_r; mop_nxt = mop_r; mrun_nxt = mrun_r;
    asgn_nxt = asgn_r; syn = 1'b0; lit_mid = 1'b0; term_mid = 1'b0;
    cur_ph = phase_r;
    if (q_tok.kind == CK_BAD) syn = 1'b1;
    else begin
      // a number ends here: fold it, then carry on as after a number
      if (phase_r == PH_NUMBER && q_tok.kind != CK_DIGIT) begin
        lit_mid = 1'b1; cur_ph = PH_AFTER;
        num_nxt = '0; mop_nxt = MOP_NONE; mrun_nxt = MR_NONE;
      end
      phase_nxt = cur_ph;
      unique case (cur_ph)
        PH_START, PH_OPND: begin
          if (q_tok.kind == CK_DIGIT) begin
            mrun_nxt = MR_NONE; num_nxt = (W+1)'(q_tok.digit); phase_nxt = PH_NUMBER;
          end else if (q_tok.kind == CK_MINUS) begin
            mrun_nxt = MR_NEG; phase_nxt = PH_UNARY;
          end else if (q_tok.kind != CK_SPACE) syn = 1'b1;
        end
        PH_UNARY: begin
          if (q_tok.kind == CK_DIGIT) begin
            num_nxt = (W+1)'(q_tok.digit); phase_nxt = PH_NUMBER;
          end else if (q_tok.kind != CK_SPACE) syn = 1'b1;
        end
        PH_NUMBER: num_nxt = (num_x10 > (W+5)'(LIM)) ? LIM + (W+1)'(1)
                             : (W+1)'(num_x10);
        PH_AFTER: begin
          unique case (q_tok.kind)
            CK_DIGIT: syn = 1'b1;
            CK_PLUS:  begin term_mid = 1'b1; asgn_nxt = 1'b0; phase_nxt = PH_OPND; end
            CK_MINUS: begin term_mid = 1'b1; mrun_nxt = MR_ODD; phase_nxt = PH_MRUN; end
            CK_MUL:   begin mop_nxt = MOP_MUL; phase_nxt = PH_OPND; end
            CK_DIV:   begin mop_nxt = MOP_DIV; phase_nxt = PH_OPND; end
            default: ;
          endcase
        end
        default: begin
          if (q_tok.kind == CK_DIGIT) begin
            asgn_nxt = (mrun_r == MR_ODD); mrun_nxt = MR_NONE;
            num_nxt = (W+1)'(q_tok.digit); phase_nxt = PH_NUMBER;
          end else if (q_tok.kind == CK_MINUS) begin
            mrun_nxt = (mrun_r == MR_ODD) ? MR_EVEN : MR_ODD;
          end else if (q_tok.kind != CK_SPACE) syn = 1'b1;
        end
      endcase
    end
    fin_fold = q_tok.last && (phase_nxt == PH_NUMBER);
    err_nxt  = (syn || (q_tok.last && !fin_fold)) ? ST_SYNTAX : err_r;
  end

  // literal value from the captured magnitude and minus flag
  always_comb begin
    lit_ovf = 1'b0; lit_v = '0;
    if (fneg_r) begin
      if (fnum_r > LIM) lit_ovf = 1'b1; else lit_v = W'(-fnum_r);
    end else if (fnum_r > LIM_M1) lit_ovf = 1'b1;
    else lit_v = W'(fnum_r);
  end

  assign sres = fasgn_r ? ({sum_r[W-1], sum_r} - {term_r[W-1], term_r})
                        : ({sum_r[W-1], sum_r} + {term_r[W-1], term_r});
  assign div_start = (seq_r == SQ_LIT) && (err_r == ST_OK) && !lit_ovf &&
                     (fmop_r == MOP_DIV) && (lit_v != '0) &&
                     !(term_r == VMIN && lit_v == {W{1'b1}});
  assign after_lit  = fterm_r ? SQ_TERM : (femit_r ? SQ_EMIT : SQ_IDLE);
  assign after_term = femit_r ? SQ_EMIT : SQ_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE; phase_r <= PH_START; sum_r <= '0; term_r <= '0; num_r <= '0;
      mop_r <= MOP_NONE; mrun_r <= MR_NONE; asgn_r <= 1'b0; err_r <= ST_OK;
      fterm_r <= 1'b0; femit_r <= 1'b0;
    end else begin
      unique case (seq_r)
        SQ_IDLE: if (q_valid) begin
          phase_r <= phase_nxt; num_r <= num_nxt; mop_r <= mop_nxt;
          mrun_r <= mrun_nxt; asgn_r <= asgn_nxt; err_r <= err_nxt;
          // the final fold sees this character's digit, an earlier fold the old state
          fnum_r  <= q_tok.last ? num_nxt : num_r;
          fneg_r  <= (q_tok.last ? mrun_nxt : mrun_r) == MR_NEG;
          fmop_r  <= q_tok.last ? mop_nxt : mop_r;
          fasgn_r <= q_tok.last ? asgn_nxt : asgn_r;
          fterm_r <= term_mid || fin_fold;
          femit_r <= q_tok.last;
          if (lit_mid || fin_fold) seq_r <= SQ_LIT;
          else if (term_mid) seq_r <= SQ_TERM;
          else if (q_tok.last) seq_r <= SQ_EMIT;
        end
        SQ_LIT: begin
          if (err_r != ST_OK) seq_r <= after_lit;
          else if (lit_ovf) begin err_r <= ST_OVF; seq_r <= after_lit; end
          else if (fmop_r == MOP_MUL) begin
            prod_r <= term_r * lit_v; seq_r <= SQ_MULC;
          end else if (fmop_r == MOP_DIV) begin
            if (lit_v == '0) begin err_r <= ST_DIV0; seq_r <= after_lit; end
            else if (!div_start) begin err_r <= ST_OVF; seq_r <= after_lit; end
            else seq_r <= SQ_DIVW;
          end else begin term_r <= lit_v; seq_r <= after_lit; end
        end
        SQ_MULC: begin
          if (prod_r > PMAX || prod_r < PMIN) err_r <= ST_OVF;
          else term_r <= prod_r[W-1:0];
          seq_r <= after_lit;
        end
        SQ_DIVW: if (div_done) begin
          term_r <= div_q; seq_r <= after_lit;
        end
        SQ_TERM: begin
          if (err_r == ST_OK) begin
            if (sres[W] != sres[W-1]) err_r <= ST_OVF; else sum_r <= sres[W-1:0];
          end
          term_r <= '0;
          seq_r <= after_term;
        end
        SQ_EMIT: if (emit_fire) begin
          seq_r <= SQ_IDLE; phase_r <= PH_START; sum_r <= '0; term_r <= '0;
          num_r <= '0; mop_r <= MOP_NONE; mrun_r <= MR_NONE; asgn_r <= 1'b0;
          err_r <= ST_OK;
        end
        default: seq_r <= SQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0; out_value <= '0; out_status <= ST_OK;
    end else if (emit_fire) begin
      out_valid  <= 1'b1;
      out_status <= err_r;
      out_value  <= (err_r == ST_OK) ? 32'(sum_r) : 32'sd0;
    end else if (!out_stall) out_valid <= 1'b0;
  end
endmodule
`default_nettype wire

// ===== rtl/integer_expression_evaluator_top.sv =====
// Top level of the streaming integer expression evaluator.
// Usage: characters enter on in_char_code with in_last_char marking the end of
// an expression; one request per character under valid/stall. On the final
// character one result leaves on out_value/out_status (0 ok, 1 syntax,
// 2 divide by zero, 3 overflow; value 0 unless ok).
// A four-entry queue parts the classifying front end from the back end, so
// characters are taken while the back end computes or the output stalls.
// Back-end steps per character: one idle step when nothing folds; the
// character that ends a number also passes SQ_LIT, and SQ_TERM if it also
// closes a + or - term; a pending multiply adds SQ_MULC, a pending divide
// adds SQ_DIVW, which waits there for the divider's done.
// From the last character to out_valid a well-formed expression passes
// SQ_LIT (then SQ_MULC or SQ_DIVW for a pending multiply or divide), SQ_TERM
// and SQ_EMIT; a syntax error at a bare final character goes straight to SQ_EMIT.
// Synchronous active-low reset clears the parse state and empties the queue.
// While out_stall is high the result holds and the back end waits at the
// result; the queue keeps filling until full, then in_stall rises.
`default_nettype none
module integer_expression_evaluator_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_char_code,
  input  wire         in_last_char,
  output logic        out_valid,
  input  wire         out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]  out_status
);
  import iee_pkg::*;
  logic q_valid, q_take;
  tok_t q_tok;

  iee_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_char_code(in_char_code), .in_last_char(in_last_char),
    .q_valid(q_valid), .q_tok(q_tok), .q_take(q_take));

  iee_back u_back (.clk(clk), .rst_n(rst_n), .q_valid(q_valid),
    .q_tok(q_tok), .q_take(q_take), .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status));

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed under stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == 32'd0)
    else $error("non-zero value with error status");
endmodule
`default_nettype wire
